>>> rtl/btlv_pkg.sv
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and constants for the BER tag-length-value splitter.
// ----------------------------------------------------------------------------
package btlv_pkg;

  localparam int unsigned MAX_LENGTH_BYTES_DEFAULT = 4;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [7:0] LEN_LONG_MARK = 8'h80;
  localparam logic [7:0] LEN_MASK      = 8'h7f;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_LEN     = 3'd1,
    PH_LONGLEN = 3'd2,
    PH_CONTENT = 3'd3,
    PH_INDEF   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic {
    ERR_NONE     = 1'b0,
    ERR_LONG_LEN = 1'b1
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tag;
    logic [31:0] unit_length;
    logic        indefinite;
    logic [7:0]  data_byte;
    logic        last_of_unit;
    err_t        error_code;
  } result_t;

endpackage

>>> rtl/ber_tlv_splitter.sv
// ----------------------------------------------------------------------------
// ber_tlv_splitter
// Splits a BER byte stream into tag-length-value units, one byte per item.
// ----------------------------------------------------------------------------
// A result is written into the result queue at the clock edge that accepts its byte.
// Throughput: one byte per cycle while in_ready is high; the parser state updates in one step.
// A byte pair of indefinite content yields two results, which drain through
// a four-entry result queue; in_ready is low while fewer than two are free.
// Reset: rst (synchronous) returns the parser to expecting a tag and empties
// the queue.
module ber_tlv_splitter #(
  parameter int unsigned MAX_LENGTH_BYTES = btlv_pkg::MAX_LENGTH_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  tag,
  output logic [31:0] unit_length,
  output logic        indefinite,
  output logic [7:0]  data_byte,
  output logic        last_of_unit,
  output logic        error_code
);

  localparam int unsigned LW = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int unsigned PW = $clog2(btlv_pkg::OUT_DEPTH);
  localparam int unsigned CW = $clog2(btlv_pkg::OUT_DEPTH + 1);

  btlv_pkg::phase_t phase, phase_next;
  logic [7:0]  tag_held, tag_held_next;
  logic [31:0] length_acc, length_acc_next;
  logic [LW-1:0] length_bytes_left, length_bytes_left_next;
  logic [31:0] content_left, content_left_next;
  logic [7:0]  pair_first, pair_first_next;
  logic        pair_half, pair_half_next;

  btlv_pkg::result_t res0, res1;
  logic [1:0]  n_res;

  btlv_pkg::result_t fifo [btlv_pkg::OUT_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  logic in_fire, out_fire;
  logic [1:0] n_push;
  logic [31:0] acc_shift;
  logic [LW-1:0] left_dec;
  logic [31:0] indef_one, indef_two;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = count <= CW'(btlv_pkg::OUT_DEPTH - 2);
  assign out_valid = count != '0;

  assign acc_shift = {length_acc[23:0], in_byte};
  assign left_dec  = length_bytes_left - LW'(1);
  assign indef_one = length_acc + 32'd1;
  assign indef_two = length_acc + 32'd2;

  always_comb begin
    phase_next             = phase;
    tag_held_next          = tag_held;
    length_acc_next        = length_acc;
    length_bytes_left_next = length_bytes_left;
    content_left_next      = content_left;
    pair_first_next        = pair_first;
    pair_half_next         = pair_half;
    n_res = 2'd0;
    res0  = '{kind: btlv_pkg::KIND_HEADER, tag: tag_held, unit_length: 32'd0,
              indefinite: 1'b0, data_byte: 8'd0, last_of_unit: 1'b0,
              error_code: btlv_pkg::ERR_NONE};
    res1  = res0;
    case (phase)
      btlv_pkg::PH_LEN: begin
        if (in_byte < btlv_pkg::LEN_LONG_MARK) begin
          n_res = 2'd1;
          length_acc_next    = {24'd0, in_byte};
          content_left_next  = {24'd0, in_byte};
          res0.unit_length   = {24'd0, in_byte};
          res0.last_of_unit  = in_byte == 8'd0;
          phase_next = (in_byte == 8'd0) ? btlv_pkg::PH_TAG : btlv_pkg::PH_CONTENT;
        end else if (in_byte == btlv_pkg::LEN_LONG_MARK) begin
          n_res = 2'd1;
          length_acc_next = 32'd0;
          pair_half_next  = 1'b0;
          pair_first_next = 8'd0;
          phase_next      = btlv_pkg::PH_INDEF;
          res0.indefinite = 1'b1;
        end else if (32'(in_byte & btlv_pkg::LEN_MASK) > 32'(MAX_LENGTH_BYTES)) begin
          n_res = 2'd1;
          phase_next        = btlv_pkg::PH_TAG;
          res0.kind         = btlv_pkg::KIND_ERROR;
          res0.last_of_unit = 1'b1;
          res0.error_code   = btlv_pkg::ERR_LONG_LEN;
        end else begin
          length_acc_next        = 32'd0;
          length_bytes_left_next = LW'(in_byte[6:0]);
          phase_next             = btlv_pkg::PH_LONGLEN;
        end
      end
      btlv_pkg::PH_LONGLEN: begin
        length_acc_next        = acc_shift;
        length_bytes_left_next = left_dec;
        if (left_dec == '0) begin
          n_res = 2'd1;
          content_left_next = acc_shift;
          res0.unit_length  = acc_shift;
          res0.last_of_unit = acc_shift == 32'd0;
          phase_next = (acc_shift == 32'd0) ? btlv_pkg::PH_TAG : btlv_pkg::PH_CONTENT;
        end
      end
      btlv_pkg::PH_CONTENT: begin
        n_res = 2'd1;
        res0.kind         = btlv_pkg::KIND_CONTENT;
        res0.unit_length  = length_acc;
        res0.data_byte    = in_byte;
        res0.last_of_unit = content_left == 32'd1;
        content_left_next = content_left - 32'd1;
        if (content_left == 32'd1) begin
          phase_next = btlv_pkg::PH_TAG;
        end
      end
      btlv_pkg::PH_INDEF: begin
        if (!pair_half) begin
          pair_first_next = in_byte;
          pair_half_next  = 1'b1;
        end else begin
          pair_half_next = 1'b0;
          if (pair_first == 8'd0 && in_byte == 8'd0) begin
            n_res = 2'd1;
            res0.kind         = btlv_pkg::KIND_END;
            res0.unit_length  = length_acc;
            res0.indefinite   = 1'b1;
            res0.last_of_unit = 1'b1;
            phase_next        = btlv_pkg::PH_TAG;
          end else begin
            n_res = 2'd2;
            length_acc_next  = indef_two;
            res0.kind        = btlv_pkg::KIND_CONTENT;
            res0.unit_length = indef_one;
            res0.indefinite  = 1'b1;
            res0.data_byte   = pair_first;
            res1             = res0;
            res1.unit_length = indef_two;
            res1.data_byte   = in_byte;
          end
        end
      end
      default: begin
        tag_held_next = in_byte;
        phase_next    = btlv_pkg::PH_LEN;
      end
    endcase
  end

  assign n_push = in_fire ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= btlv_pkg::PH_TAG;
      tag_held          <= 8'd0;
      length_acc        <= 32'd0;
      length_bytes_left <= '0;
      content_left      <= 32'd0;
      pair_first        <= 8'd0;
      pair_half         <= 1'b0;
      wr_ptr            <= '0;
      rd_ptr            <= '0;
      count             <= '0;
    end else begin
      if (in_fire) begin
        phase             <= phase_next;
        tag_held          <= tag_held_next;
        length_acc        <= length_acc_next;
        length_bytes_left <= length_bytes_left_next;
        content_left      <= content_left_next;
        pair_first        <= pair_first_next;
        pair_half         <= pair_half_next;
      end
      wr_ptr <= wr_ptr + PW'(n_push);
      if (out_fire) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(n_push) - CW'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo[wr_ptr] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo[wr_ptr + PW'(1)] <= res1;
    end
  end

  assign kind         = fifo[rd_ptr].kind;
  assign tag          = fifo[rd_ptr].tag;
  assign unit_length  = fifo[rd_ptr].unit_length;
  assign indefinite   = fifo[rd_ptr].indefinite;
  assign data_byte    = fifo[rd_ptr].data_byte;
  assign last_of_unit = fifo[rd_ptr].last_of_unit;
  assign error_code   = fifo[rd_ptr].error_code;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(btlv_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CW'($past(n_push)) - CW'($past(out_fire)))
    else $error("result queue count out of step with pushes and pops");

  a_content_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == btlv_pkg::PH_CONTENT |-> content_left != 32'd0)
    else $error("content phase with no bytes left");

  a_pair_only_indef: assert property (@(posedge clk) disable iff (rst)
    n_res == 2'd2 |-> phase == btlv_pkg::PH_INDEF && pair_half)
    else $error("two results outside a completed indefinite pair");

endmodule
